// File: design/mhb_pkg.sv
package mhb_pkg;

    localparam int FEATURES_DEF  = 1024;
    localparam int ROWS_MAX_DEF  = 8;
    localparam int BANDS_MAX_DEF = 16;

    localparam int FEAT_W    = 10;
    localparam int POS_W     = 10;
    localparam int FUNC_W    = 7;
    localparam int BAND_W    = 4;
    localparam int HASH_W    = 32;
    localparam int BUCKET_W  = 31;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [HASH_W-1:0] HASH_SEED  = 32'd7;
    localparam int                HASH_SHIFT = 5;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BANDS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BUCKET = 2'd2;

    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_FEATURE = 1'b1;

    typedef struct packed {
        logic                mode;
        logic [FUNC_W-1:0]   func;
        logic [FEAT_W-1:0]   feat;
        logic [POS_W-1:0]    pos;
        logic                last;
        logic                in_range;
    } mhb_cmd_t;

    function automatic logic [HASH_W-1:0] hash_step(input logic [HASH_W-1:0] h,
                                                    input logic [FEAT_W-1:0] e);
        hash_step = (h << HASH_SHIFT) - h + {{(HASH_W-FEAT_W){1'b0}}, e};
    endfunction

endpackage

// File: design/mhb_ram.sv
module mhb_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: design/mhb_front.sv
module mhb_front
    import mhb_pkg::*;
#(
    parameter int FEATURES  = FEATURES_DEF,
    parameter int ROWS_MAX  = ROWS_MAX_DEF,
    parameter int BANDS_MAX = BANDS_MAX_DEF,
    parameter int QDEPTH    = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              mode,
    input  logic [FUNC_W-1:0] function_index,
    input  logic [FEAT_W-1:0] feature,
    input  logic [POS_W-1:0]  position,
    input  logic              last,
    output logic              q_valid,
    output mhb_cmd_t          q_head,
    input  logic              q_pop
);

    localparam int FUNCS = ROWS_MAX * BANDS_MAX;
    localparam int QA_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QC_W  = $clog2(QDEPTH + 1);

    mhb_cmd_t            q_reg [QDEPTH];
    logic [QA_W-1:0]     wp_reg, rp_reg;
    logic [QC_W-1:0]     cnt_reg;
    logic                push;
    mhb_cmd_t            cmd;

    always_comb
    begin
        cmd.mode = mode;
        cmd.func = function_index;
        cmd.feat = feature;
        cmd.pos  = position;
        cmd.last = last;
        if (mode == MODE_LOAD)
        begin
            cmd.in_range = (32'(function_index) < 32'(FUNCS)) &&
                           (32'(feature) < 32'(FEATURES));
        end
        else
        begin
            cmd.in_range = 32'(feature) < 32'(FEATURES);
        end
    end

    assign busy    = (cnt_reg == QC_W'(QDEPTH));
    assign push    = start && !busy;
    assign q_valid = (cnt_reg != '0);
    assign q_head  = q_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= (32'(wp_reg) == QDEPTH - 1) ? '0 : wp_reg + 1'b1;
            end
            if (q_pop)
            begin
                rp_reg <= (32'(rp_reg) == QDEPTH - 1) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + QC_W'(push) - QC_W'(q_pop);
        end
    end

endmodule

// File: design/mhb_back.sv
module mhb_back
    import mhb_pkg::*;
#(
    parameter int FEATURES  = FEATURES_DEF,
    parameter int ROWS_MAX  = ROWS_MAX_DEF,
    parameter int BANDS_MAX = BANDS_MAX_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [3:0]          rows_in_use,
    input  logic [4:0]          bands_in_use,
    input  logic [4:0]          bucket_bits,
    input  logic                q_valid,
    input  mhb_cmd_t            q_head,
    output logic                q_pop,
    output logic                done,
    output logic [BAND_W-1:0]   band,
    output logic [HASH_W-1:0]   signature_hash,
    output logic [BUCKET_W-1:0] home_bucket,
    output logic                last_band,
    output logic                idle
);

    localparam int FA_W   = $clog2(FEATURES);
    localparam int BA_W   = (BANDS_MAX > 1) ? $clog2(BANDS_MAX) : 1;
    localparam int BC_W   = $clog2(BANDS_MAX + 1);
    localparam int RA_W   = (ROWS_MAX > 1) ? $clog2(ROWS_MAX) : 1;
    localparam int RC_W   = $clog2(ROWS_MAX + 1);
    localparam int MADR_W = BA_W + FA_W;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_READ = 5'b00010,
        ST_UPD  = 5'b00100,
        ST_HASH = 5'b01000,
        ST_OUT  = 5'b10000
    } st_t;

    st_t                 st_reg, st_next;
    mhb_cmd_t            cmd_reg;
    logic [BA_W-1:0]     rb_reg;
    logic [BA_W-1:0]     ub_reg;
    logic [BA_W-1:0]     ob_reg;
    logic [RA_W-1:0]     hr_reg;
    logic [HASH_W-1:0]   h_reg;
    logic                ostart_reg;
    logic                upd_v_reg;
    logic [BC_W-1:0]     bands_c;
    logic [RC_W-1:0]     rows_c;
    logic [POS_W-1:0]    bpos_reg [ROWS_MAX][BANDS_MAX];
    logic [FEAT_W-1:0]   bfeat_reg [ROWS_MAX][BANDS_MAX];
    logic [POS_W-1:0]    rk [ROWS_MAX];
    logic [MADR_W-1:0]   raddr, waddr;
    logic [HASH_W-1:0]   mask;
    logic                rd_last;

    always_comb
    begin
        if (bands_in_use == '0)
            bands_c = BC_W'(1);
        else if (32'(bands_in_use) > BANDS_MAX)
            bands_c = BC_W'(BANDS_MAX);
        else
            bands_c = BC_W'(bands_in_use);
        if (rows_in_use == '0)
            rows_c = RC_W'(1);
        else if (32'(rows_in_use) > ROWS_MAX)
            rows_c = RC_W'(ROWS_MAX);
        else
            rows_c = RC_W'(rows_in_use);
    end

    assign raddr = {rb_reg, cmd_reg.feat[FA_W-1:0]};
    assign waddr = {q_head.func[FUNC_W-1:RA_W], q_head.feat[FA_W-1:0]};
    assign rd_last = (32'(rb_reg) == BANDS_MAX - 1);

    genvar gr;
    generate
        for (gr = 0; gr < ROWS_MAX; gr++)
        begin : g_row
            mhb_ram #(.WIDTH(POS_W), .DEPTH(BANDS_MAX * FEATURES)) u_rank (
                .clk   (clk),
                .we    (st_reg == ST_IDLE && q_valid && q_head.mode == MODE_LOAD &&
                        q_head.in_range && q_head.func[RA_W-1:0] == RA_W'(gr)),
                .waddr (waddr),
                .wdata (q_head.pos),
                .re    (st_reg == ST_READ),
                .raddr (raddr),
                .rdata (rk[gr])
            );
        end
    endgenerate

    always_comb
    begin
        st_next = st_reg;
        q_pop   = 1'b0;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (q_head.mode == MODE_FEATURE)
                    begin
                        if (q_head.in_range)
                            st_next = ST_READ;
                        else if (q_head.last)
                            st_next = ST_HASH;
                    end
                end
            end
            ST_READ:
            begin
                if (rd_last)
                    st_next = ST_UPD;
            end
            ST_UPD:
            begin
                st_next = cmd_reg.last ? ST_HASH : ST_IDLE;
            end
            ST_HASH:
            begin
                if (32'(hr_reg) + 1 == 32'(rows_c))
                    st_next = ST_OUT;
            end
            ST_OUT:
            begin
                st_next = (32'(ob_reg) + 1 == 32'(bands_c)) ? ST_IDLE : ST_HASH;
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    // the update of a band follows its read in the next cycle
    always_ff @(posedge clk)
    begin
        if (st_reg == ST_IDLE && q_valid)
            cmd_reg <= q_head;
        if (upd_v_reg)
        begin
            for (int r = 0; r < ROWS_MAX; r++)
            begin
                if (ostart_reg || rk[r] < bpos_reg[r][ub_reg])
                begin
                    bpos_reg[r][ub_reg]  <= rk[r];
                    bfeat_reg[r][ub_reg] <= cmd_reg.feat;
                end
            end
        end
        if (st_reg == ST_HASH)
            h_reg <= hash_step(h_reg, bfeat_reg[hr_reg][ob_reg]);
        else if (st_reg != ST_OUT || st_next == ST_HASH)
            h_reg <= HASH_SEED;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= ST_IDLE;
            rb_reg     <= '0;
            ub_reg     <= '0;
            ob_reg     <= '0;
            hr_reg     <= '0;
            ostart_reg <= 1'b1;
            upd_v_reg  <= 1'b0;
        end
        else
        begin
            st_reg    <= st_next;
            upd_v_reg <= (st_reg == ST_READ);
            ub_reg    <= rb_reg;
            if (st_reg == ST_READ)
                rb_reg <= rd_last ? '0 : rb_reg + 1'b1;
            if (st_reg == ST_UPD)
                ostart_reg <= 1'b0;
            if (st_reg == ST_HASH)
                hr_reg <= (st_next == ST_OUT) ? '0 : hr_reg + 1'b1;
            if (st_reg == ST_OUT)
            begin
                ob_reg <= (st_next == ST_IDLE) ? '0 : ob_reg + 1'b1;
                if (st_next == ST_IDLE)
                    ostart_reg <= 1'b1;
            end
        end
    end

    assign mask = (bucket_bits == '0) ? '0 : (HASH_W'(1) << bucket_bits) - HASH_W'(1);

    assign done           = (st_reg == ST_OUT);
    assign band           = BAND_W'(ob_reg);
    assign signature_hash = h_reg;
    assign home_bucket    = BUCKET_W'(h_reg & mask);
    assign last_band      = (32'(ob_reg) + 1 == 32'(bands_c));
    assign idle           = (st_reg == ST_IDLE) && !q_valid && !upd_v_reg;

endmodule

// File: design/minhash_band_signature_hash.sv
// Channel  | Signals                                       | Handshake
// input    | mode function_index feature position last     | start && !busy
// result   | band signature_hash home_bucket last_band     | done, one cycle
// config   | cfg_we cfg_index cfg_data                     | cfg_we
// Load: written to rank memory when the back end pops it. Feature: pop, one rank
// read per band with all rows of a band read in parallel from per-row
// memories, then the last band's update.
// Flush after last: one row of the hash per cycle, for each band in use.
// Two-entry queue decouples start from the back end; busy when it is full.
// Reset is asynchronous; rank memory is undefined until loaded; no clearing.
module minhash_band_signature_hash
    import mhb_pkg::*;
#(
    parameter int FEATURES  = FEATURES_DEF,
    parameter int ROWS_MAX  = ROWS_MAX_DEF,
    parameter int BANDS_MAX = BANDS_MAX_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 mode,
    input  logic [FUNC_W-1:0]    function_index,
    input  logic [FEAT_W-1:0]    feature,
    input  logic [POS_W-1:0]     position,
    input  logic                 last,
    output logic                 done,
    output logic [BAND_W-1:0]    band,
    output logic [HASH_W-1:0]    signature_hash,
    output logic [BUCKET_W-1:0]  home_bucket,
    output logic                 last_band,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic [3:0] rows_reg;
    logic [4:0] bands_reg;
    logic [4:0] bucket_reg;
    logic       q_valid, q_pop, idle;
    mhb_cmd_t   q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg   <= 4'd8;
            bands_reg  <= 5'd16;
            bucket_reg <= 5'd10;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROWS:   rows_reg   <= cfg_data[3:0];
                REG_BANDS:  bands_reg  <= cfg_data;
                REG_BUCKET: bucket_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    mhb_front #(.FEATURES(FEATURES), .ROWS_MAX(ROWS_MAX), .BANDS_MAX(BANDS_MAX)) u_front (
        .clk, .rst_n, .start, .busy, .mode, .function_index, .feature, .position, .last,
        .q_valid, .q_head, .q_pop
    );

    mhb_back #(.FEATURES(FEATURES), .ROWS_MAX(ROWS_MAX), .BANDS_MAX(BANDS_MAX)) u_back (
        .clk, .rst_n,
        .rows_in_use(rows_reg), .bands_in_use(bands_reg), .bucket_bits(bucket_reg),
        .q_valid, .q_head, .q_pop, .done, .band, .signature_hash, .home_bucket,
        .last_band, .idle
    );

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
        else $error("pop from empty queue");
    a_bucket: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (home_bucket == (signature_hash[BUCKET_W-1:0] & home_bucket)))
        else $error("bucket not a subset of hash");
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n) idle |-> !done)
        else $error("result while idle");
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        done && last_band |=> !done)
        else $error("result after last band");

endmodule
